FILE: rtl/core/lqi_pkg.sv
// lqi_pkg: shared types and filter arithmetic for the luma quarter-pel interpolator
`timescale 1ns / 1ps

package lqi_pkg;

  localparam int unsigned NumTaps   = 6;
  localparam int unsigned PixW      = 8;
  localparam int unsigned RowW      = NumTaps * PixW;
  localparam int unsigned HsumW     = 15;
  localparam int unsigned CentreW   = 21;

  typedef logic [PixW-1:0]             pix_t;
  typedef logic [RowW-1:0]             row_t;
  typedef logic [NumTaps-1:0][RowW-1:0] window_t;
  typedef logic signed [HsumW-1:0]     hsum_t;
  typedef logic signed [CentreW-1:0]   centre_t;
  typedef logic [1:0]                  phase_t;

  // 6-tap filter (1,-5,20,20,-5,1) over plain samples, range -2550..10710
  function automatic hsum_t tap6_pix(input pix_t p0, input pix_t p1, input pix_t p2,
                                     input pix_t p3, input pix_t p4, input pix_t p5);
    logic signed [15:0] a0, a1, a2, a3, a4, a5, s;
    a0 = $signed({8'b0, p0});
    a1 = $signed({8'b0, p1});
    a2 = $signed({8'b0, p2});
    a3 = $signed({8'b0, p3});
    a4 = $signed({8'b0, p4});
    a5 = $signed({8'b0, p5});
    s  = a0 - 16'sd5 * a1 + 16'sd20 * a2 + 16'sd20 * a3 - 16'sd5 * a4 + a5;
    return s[HsumW-1:0];
  endfunction

  // same filter over the unclipped horizontal intermediates
  function automatic centre_t tap6_mid(input hsum_t h0, input hsum_t h1, input hsum_t h2,
                                       input hsum_t h3, input hsum_t h4, input hsum_t h5);
    centre_t a0, a1, a2, a3, a4, a5;
    a0 = centre_t'(h0);
    a1 = centre_t'(h1);
    a2 = centre_t'(h2);
    a3 = centre_t'(h3);
    a4 = centre_t'(h4);
    a5 = centre_t'(h5);
    return a0 - 21'sd5 * a1 + 21'sd20 * a2 + 21'sd20 * a3 - 21'sd5 * a4 + a5;
  endfunction

  // round by +16 >> 5 and clip to 0..255
  function automatic pix_t clip_half(input hsum_t v);
    logic signed [15:0] t;
    logic [10:0]        u;
    pix_t               r;
    t = 16'(v) + 16'sd16;
    u = t[15:5];
    if (t < 0) begin
      r = '0;
    end else if (u > 11'd255) begin
      r = 8'd255;
    end else begin
      r = u[7:0];
    end
    return r;
  endfunction

  // round by +512 >> 10 and clip to 0..255
  function automatic pix_t clip_centre(input centre_t v);
    logic signed [21:0] t;
    logic [11:0]        u;
    pix_t               r;
    t = 22'(v) + 22'sd512;
    u = t[21:10];
    if (t < 0) begin
      r = '0;
    end else if (u > 12'd255) begin
      r = 8'd255;
    end else begin
      r = u[7:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/lqi_filter_stage.sv
// lqi_filter_stage: first stage, horizontal and vertical 6-tap sums of the window
`timescale 1ns / 1ps

module lqi_filter_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             in_vld,
  input  lqi_pkg::window_t window,
  input  lqi_pkg::phase_t  phase_x,
  input  lqi_pkg::phase_t  phase_y,
  output logic             out_vld,
  output lqi_pkg::hsum_t   hsum [lqi_pkg::NumTaps],
  output lqi_pkg::hsum_t   vsum_g,
  output lqi_pkg::hsum_t   vsum_h,
  output lqi_pkg::pix_t    pix_g,
  output lqi_pkg::pix_t    pix_h,
  output lqi_pkg::pix_t    pix_m,
  output lqi_pkg::phase_t  px,
  output lqi_pkg::phase_t  py
);
  import lqi_pkg::*;

  function automatic pix_t pel(input window_t w, input int unsigned r, input int unsigned c);
    return w[r][PixW*c +: PixW];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int r = 0; r < NumTaps; r++) begin
        hsum[r] <= tap6_pix(pel(window, r, 0), pel(window, r, 1), pel(window, r, 2),
                            pel(window, r, 3), pel(window, r, 4), pel(window, r, 5));
      end
      vsum_g <= tap6_pix(pel(window, 0, 2), pel(window, 1, 2), pel(window, 2, 2),
                         pel(window, 3, 2), pel(window, 4, 2), pel(window, 5, 2));
      vsum_h <= tap6_pix(pel(window, 0, 3), pel(window, 1, 3), pel(window, 2, 3),
                         pel(window, 3, 3), pel(window, 4, 3), pel(window, 5, 3));
      pix_g  <= pel(window, 2, 2);
      pix_h  <= pel(window, 2, 3);
      pix_m  <= pel(window, 3, 2);
      px     <= phase_x;
      py     <= phase_y;
    end
  end

endmodule

FILE: rtl/core/lqi_centre_stage.sv
// lqi_centre_stage: second stage, centre 6-tap sum and rounding of the half samples
`timescale 1ns / 1ps

module lqi_centre_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             in_vld,
  input  lqi_pkg::hsum_t   hsum [lqi_pkg::NumTaps],
  input  lqi_pkg::hsum_t   vsum_g,
  input  lqi_pkg::hsum_t   vsum_h,
  input  lqi_pkg::pix_t    in_g,
  input  lqi_pkg::pix_t    in_h,
  input  lqi_pkg::pix_t    in_m,
  input  lqi_pkg::phase_t  in_px,
  input  lqi_pkg::phase_t  in_py,
  output logic             out_vld,
  output lqi_pkg::centre_t j_sum,
  output lqi_pkg::pix_t    half_b,
  output lqi_pkg::pix_t    half_h,
  output lqi_pkg::pix_t    half_s,
  output lqi_pkg::pix_t    half_m,
  output lqi_pkg::pix_t    pix_g,
  output lqi_pkg::pix_t    pix_h,
  output lqi_pkg::pix_t    pix_m,
  output lqi_pkg::phase_t  px,
  output lqi_pkg::phase_t  py
);
  import lqi_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      j_sum  <= tap6_mid(hsum[0], hsum[1], hsum[2], hsum[3], hsum[4], hsum[5]);
      half_b <= clip_half(hsum[2]);
      half_s <= clip_half(hsum[3]);
      half_h <= clip_half(vsum_g);
      half_m <= clip_half(vsum_h);
      pix_g  <= in_g;
      pix_h  <= in_h;
      pix_m  <= in_m;
      px     <= in_px;
      py     <= in_py;
    end
  end

endmodule

FILE: rtl/core/lqi_select_stage.sv
// lqi_select_stage: last stage, centre rounding, phase select and quarter averaging
`timescale 1ns / 1ps

module lqi_select_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             in_vld,
  input  lqi_pkg::centre_t j_sum,
  input  lqi_pkg::pix_t    half_b,
  input  lqi_pkg::pix_t    half_h,
  input  lqi_pkg::pix_t    half_s,
  input  lqi_pkg::pix_t    half_m,
  input  lqi_pkg::pix_t    pix_g,
  input  lqi_pkg::pix_t    pix_h,
  input  lqi_pkg::pix_t    pix_m,
  input  lqi_pkg::phase_t  px,
  input  lqi_pkg::phase_t  py,
  output logic             out_vld,
  output lqi_pkg::pix_t    sample
);
  import lqi_pkg::*;

  // sample positions in raster order of the quarter grid
  typedef enum logic [3:0] {
    POS_INT = 4'd0,  POS_A = 4'd1,  POS_B = 4'd2,  POS_C = 4'd3,
    POS_D   = 4'd4,  POS_E = 4'd5,  POS_F = 4'd6,  POS_G = 4'd7,
    POS_H   = 4'd8,  POS_I = 4'd9,  POS_J = 4'd10, POS_K = 4'd11,
    POS_N   = 4'd12, POS_P = 4'd13, POS_Q = 4'd14, POS_R = 4'd15
  } pos_t;

  pos_t       pos;
  pix_t       half_j;
  pix_t       op_a;
  pix_t       op_b;
  logic [8:0] avg_sum;

  assign pos    = pos_t'({py, px});
  assign half_j = clip_centre(j_sum);

  // full and half positions average a sample with itself
  always_comb begin
    unique case (pos)
      POS_INT: begin op_a = pix_g;  op_b = pix_g;  end
      POS_A:   begin op_a = pix_g;  op_b = half_b; end
      POS_B:   begin op_a = half_b; op_b = half_b; end
      POS_C:   begin op_a = pix_h;  op_b = half_b; end
      POS_D:   begin op_a = pix_g;  op_b = half_h; end
      POS_E:   begin op_a = half_b; op_b = half_h; end
      POS_F:   begin op_a = half_b; op_b = half_j; end
      POS_G:   begin op_a = half_b; op_b = half_m; end
      POS_H:   begin op_a = half_h; op_b = half_h; end
      POS_I:   begin op_a = half_h; op_b = half_j; end
      POS_J:   begin op_a = half_j; op_b = half_j; end
      POS_K:   begin op_a = half_j; op_b = half_m; end
      POS_N:   begin op_a = pix_m;  op_b = half_h; end
      POS_P:   begin op_a = half_h; op_b = half_s; end
      POS_Q:   begin op_a = half_j; op_b = half_s; end
      default: begin op_a = half_m; op_b = half_s; end
    endcase
  end

  assign avg_sum = {1'b0, op_a} + {1'b0, op_b} + 9'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sample <= avg_sum[8:1];
    end
  end

endmodule

FILE: rtl/core/luma_quarter_pel_interpolator_top.sv
// luma_quarter_pel_interpolator_top: top level of the luma quarter-pel interpolator
`timescale 1ns / 1ps

// Luma quarter-sample interpolator. Each request carries a 6x6 window of 8-bit
// reference samples (columns x-2..x+3, rows y-2..y+3, column k of a row in
// bits 8k+7..8k) and a quarter phase, and yields one predicted sample. The
// work runs through three register stages: the six horizontal and two
// vertical 6-tap sums, then the centre 6-tap sum over the unclipped horizontal
// sums together with rounding and clipping of the half samples, then the
// centre rounding, the phase select and the rounded-up average. A request
// can enter in every cycle while req_stall is low, and its sample leaves the
// select stage as pred_sample. Each stage advances when it is empty or the stage
// after it advances, so a stall on the output backs up only as far as the
// first empty stage, and bubbles are squeezed out. req_stall follows
// pred_stall combinationally through that chain.

module luma_quarter_pel_interpolator_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  lqi_pkg::row_t       window_row0,
  input  lqi_pkg::row_t       window_row1,
  input  lqi_pkg::row_t       window_row2,
  input  lqi_pkg::row_t       window_row3,
  input  lqi_pkg::row_t       window_row4,
  input  lqi_pkg::row_t       window_row5,
  input  lqi_pkg::phase_t     phase_x,
  input  lqi_pkg::phase_t     phase_y,
  output logic                pred_valid,
  input  logic                pred_stall,
  output lqi_pkg::pix_t       pred_sample
);
  import lqi_pkg::*;

  window_t window;

  // stage 1 outputs
  logic    s1_vld;
  hsum_t   s1_hsum [NumTaps];
  hsum_t   s1_vsum_g;
  hsum_t   s1_vsum_h;
  pix_t    s1_g, s1_h, s1_m;
  phase_t  s1_px, s1_py;

  // stage 2 outputs
  logic    s2_vld;
  centre_t s2_j_sum;
  pix_t    s2_b, s2_hh, s2_s, s2_mm;
  pix_t    s2_g, s2_h, s2_m;
  phase_t  s2_px, s2_py;

  // per-stage advance, back to front
  logic    adv1, adv2, adv3;

  assign window = {window_row5, window_row4, window_row3,
                   window_row2, window_row1, window_row0};

  assign adv3      = !pred_valid || !pred_stall;
  assign adv2      = !s2_vld || adv3;
  assign adv1      = !s1_vld || adv2;
  assign req_stall = !adv1;

  lqi_filter_stage u_filter (
    .clk     (clk),
    .rst     (rst),
    .advance (adv1),
    .in_vld  (req_valid),
    .window  (window),
    .phase_x (phase_x),
    .phase_y (phase_y),
    .out_vld (s1_vld),
    .hsum    (s1_hsum),
    .vsum_g  (s1_vsum_g),
    .vsum_h  (s1_vsum_h),
    .pix_g   (s1_g),
    .pix_h   (s1_h),
    .pix_m   (s1_m),
    .px      (s1_px),
    .py      (s1_py)
  );

  lqi_centre_stage u_centre (
    .clk     (clk),
    .rst     (rst),
    .advance (adv2),
    .in_vld  (s1_vld),
    .hsum    (s1_hsum),
    .vsum_g  (s1_vsum_g),
    .vsum_h  (s1_vsum_h),
    .in_g    (s1_g),
    .in_h    (s1_h),
    .in_m    (s1_m),
    .in_px   (s1_px),
    .in_py   (s1_py),
    .out_vld (s2_vld),
    .j_sum   (s2_j_sum),
    .half_b  (s2_b),
    .half_h  (s2_hh),
    .half_s  (s2_s),
    .half_m  (s2_mm),
    .pix_g   (s2_g),
    .pix_h   (s2_h),
    .pix_m   (s2_m),
    .px      (s2_px),
    .py      (s2_py)
  );

  // output register doubles as the last pipeline stage
  lqi_select_stage u_select (
    .clk     (clk),
    .rst     (rst),
    .advance (adv3),
    .in_vld  (s2_vld),
    .j_sum   (s2_j_sum),
    .half_b  (s2_b),
    .half_h  (s2_hh),
    .half_s  (s2_s),
    .half_m  (s2_mm),
    .pix_g   (s2_g),
    .pix_h   (s2_h),
    .pix_m   (s2_m),
    .px      (s2_px),
    .py      (s2_py),
    .out_vld (pred_valid),
    .sample  (pred_sample)
  );

endmodule

FILE: test/luma_quarter_pel_interpolator_top_test.sv
// checks every quarter-pel position of the luma interpolator against an in-bench model
`timescale 1ns / 1ps

module luma_quarter_pel_interpolator_top_test;

  // the sixteen quarter-sample positions, indexed by {phase_y, phase_x}
  typedef enum logic [3:0] {
    POS_FULL, POS_A, POS_B, POS_C,
    POS_D,    POS_E, POS_F, POS_G,
    POS_H,    POS_I, POS_J, POS_K,
    POS_N,    POS_P, POS_Q, POS_R
  } qpel_pos_t;

  // one request as the driver sees it; hold_for_drain pauses until the pipe is empty
  typedef struct {
    lqi_pkg::window_t win;
    qpel_pos_t        pos;
    bit               hold_for_drain;
  } interp_req_t;

  localparam int CycleLimit  = 400000;
  localparam int ReportLimit = 10;
  localparam int RandomReqs  = 1530;
  localparam int SettleWait  = 20;

  logic             clk;
  logic             rst;
  logic             req_valid;
  logic             req_stall;
  lqi_pkg::row_t    window_row0;
  lqi_pkg::row_t    window_row1;
  lqi_pkg::row_t    window_row2;
  lqi_pkg::row_t    window_row3;
  lqi_pkg::row_t    window_row4;
  lqi_pkg::row_t    window_row5;
  lqi_pkg::phase_t  phase_x;
  lqi_pkg::phase_t  phase_y;
  logic             pred_valid;
  logic             pred_stall;
  lqi_pkg::pix_t    pred_sample;

  interp_req_t      pending_reqs[$];
  lqi_pkg::pix_t    expected_samples[$];
  int               mismatches;
  int               cycle_count;
  int               gap_left;
  int               stall_left;
  bit               req_taken;
  bit               send_calm;
  bit               recv_calm;

  luma_quarter_pel_interpolator_top dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .window_row0 (window_row0),
    .window_row1 (window_row1),
    .window_row2 (window_row2),
    .window_row3 (window_row3),
    .window_row4 (window_row4),
    .window_row5 (window_row5),
    .phase_x     (phase_x),
    .phase_y     (phase_y),
    .pred_valid  (pred_valid),
    .pred_stall  (pred_stall),
    .pred_sample (pred_sample)
  );

  // ---------------------------------------------------------------------------
  // sample model
  // ---------------------------------------------------------------------------

  // sample of row r, column c of the window (column c sits in bits 8c+7..8c)
  function automatic int pel(input lqi_pkg::window_t win, input int r, input int c);
    return int'(win[r][8*c +: 8]);
  endfunction

  // the six-tap (1,-5,20,20,-5,1) kernel, full precision
  function automatic int filt6(input int a0, input int a1, input int a2,
                               input int a3, input int a4, input int a5);
    return a0 - 5 * a1 + 20 * a2 + 20 * a3 - 5 * a4 + a5;
  endfunction

  // add rounding offset, floor-shift, clip to 0..255; anything below zero goes to 0
  function automatic int round_clip(input int v, input int offset, input int sh);
    int t;
    t = v + offset;
    if (t < 0) return 0;
    t = t >>> sh;
    return (t > 255) ? 255 : t;
  endfunction

  function automatic int avg_up(input int a, input int b);
    return (a + b + 1) >> 1;
  endfunction

  function automatic lqi_pkg::pix_t interp_sample(input lqi_pkg::window_t win,
                                                  input lqi_pkg::phase_t fx,
                                                  input lqi_pkg::phase_t fy);
    int row_sum[6];
    int full_g, full_h, full_m;
    int half_b, half_h, half_m, half_s, half_j;
    int col2, col3;
    int res;
    for (int r = 0; r < 6; r++) begin
      row_sum[r] = filt6(pel(win, r, 0), pel(win, r, 1), pel(win, r, 2),
                         pel(win, r, 3), pel(win, r, 4), pel(win, r, 5));
    end
    col2 = filt6(pel(win, 0, 2), pel(win, 1, 2), pel(win, 2, 2),
                 pel(win, 3, 2), pel(win, 4, 2), pel(win, 5, 2));
    col3 = filt6(pel(win, 0, 3), pel(win, 1, 3), pel(win, 2, 3),
                 pel(win, 3, 3), pel(win, 4, 3), pel(win, 5, 3));
    full_g = pel(win, 2, 2);
    full_h = pel(win, 2, 3);
    full_m = pel(win, 3, 2);
    half_b = round_clip(row_sum[2], 16, 5);
    half_s = round_clip(row_sum[3], 16, 5);
    half_h = round_clip(col2, 16, 5);
    half_m = round_clip(col3, 16, 5);
    // centre: vertical pass over the unclipped horizontal sums
    half_j = round_clip(filt6(row_sum[0], row_sum[1], row_sum[2],
                              row_sum[3], row_sum[4], row_sum[5]), 512, 10);
    case (qpel_pos_t'({fy, fx}))
      POS_FULL: res = full_g;
      POS_A:    res = avg_up(full_g, half_b);
      POS_B:    res = half_b;
      POS_C:    res = avg_up(full_h, half_b);
      POS_D:    res = avg_up(full_g, half_h);
      POS_E:    res = avg_up(half_b, half_h);
      POS_F:    res = avg_up(half_b, half_j);
      POS_G:    res = avg_up(half_b, half_m);
      POS_H:    res = half_h;
      POS_I:    res = avg_up(half_h, half_j);
      POS_J:    res = half_j;
      POS_K:    res = avg_up(half_j, half_m);
      POS_N:    res = avg_up(full_m, half_h);
      POS_P:    res = avg_up(half_h, half_s);
      POS_Q:    res = avg_up(half_j, half_s);
      default:  res = avg_up(half_m, half_s);
    endcase
    return lqi_pkg::pix_t'(res);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // random row in one of three flavors: uniform, saturated bytes, smooth ramp
  function automatic lqi_pkg::row_t rand_row(input int flavor);
    lqi_pkg::row_t row;
    int            level;
    int            pick;
    level = $urandom_range(0, 255);
    for (int c = 0; c < 6; c++) begin
      case (flavor)
        0: row[8*c +: 8] = 8'($urandom);
        1: begin
          pick = $urandom_range(0, 2);
          row[8*c +: 8] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
        end
        default: begin
          level = level + $urandom_range(0, 16) - 8;
          if (level < 0) level = 0;
          if (level > 255) level = 255;
          row[8*c +: 8] = 8'(level);
        end
      endcase
    end
    return row;
  endfunction

  function automatic lqi_pkg::window_t rand_window(input int flavor);
    lqi_pkg::window_t win;
    for (int r = 0; r < 6; r++) win[r] = rand_row(flavor);
    return win;
  endfunction

  // samples set to 255 wherever the kernel weight has the wanted sign, else 0;
  // drives the filter sums to their most negative or most positive values
  function automatic lqi_pkg::window_t sign_pattern(input int want_sign, input bit horiz,
                                                    input bit vert);
    int               wt[6] = '{1, -5, 20, 20, -5, 1};
    int               w;
    lqi_pkg::window_t win;
    for (int r = 0; r < 6; r++) begin
      for (int c = 0; c < 6; c++) begin
        w = (horiz ? wt[c] : 1) * (vert ? wt[r] : 1);
        win[r][8*c +: 8] = (w * want_sign > 0) ? 8'hFF : 8'h00;
      end
    end
    return win;
  endfunction

  task automatic queue_req(input lqi_pkg::window_t win, input qpel_pos_t pos,
                           input bit hold_for_drain);
    interp_req_t item;
    item.win            = win;
    item.pos            = pos;
    item.hold_for_drain = hold_for_drain;
    pending_reqs.push_back(item);
  endtask

  // mostly back-to-back, sometimes a short gap, now and then a long pause
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run watchdog: a stuck handshake or a lost sample ends here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: sample both handshakes at the rising edge
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    lqi_pkg::pix_t want;
    req_taken = 1'b0;
    if (!rst) begin
      // accepted request: predict its sample from the values on the pins
      if (req_valid && !req_stall) begin
        req_taken = 1'b1;
        expected_samples.push_back(interp_sample(
            {window_row5, window_row4, window_row3, window_row2, window_row1, window_row0},
            phase_x, phase_y));
      end
      // accepted sample: compare with the oldest prediction
      if (pred_valid && !pred_stall) begin
        if (expected_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("unexpected sample %0d with nothing pending at %0t", pred_sample, $realtime);
        end else begin
          want = expected_samples.pop_front();
          if (pred_sample !== want) begin
            mismatches++;
            if (mismatches <= ReportLimit)
              $display("pred_sample mismatch at %0t: expected %0d, got %0d",
                       $realtime, want, pred_sample);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request driver: falling edge, fed from pending_reqs
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    interp_req_t nxt;
    bit          next_valid;
    next_valid = req_valid;
    if (rst) begin
      next_valid = 1'b0;
    end else begin
      // a request that went in at the last edge frees the pins
      if (req_taken) next_valid = 1'b0;
      if (!next_valid) begin
        if (gap_left > 0 && !send_calm) begin
          gap_left--;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].hold_for_drain && expected_samples.size() != 0)) begin
          // a drain-marked request waits until every sample in flight is back
          nxt = pending_reqs.pop_front();
          window_row0 <= nxt.win[0];
          window_row1 <= nxt.win[1];
          window_row2 <= nxt.win[2];
          window_row3 <= nxt.win[3];
          window_row4 <= nxt.win[4];
          window_row5 <= nxt.win[5];
          {phase_y, phase_x} <= nxt.pos;
          next_valid = 1'b1;
          gap_left   = send_calm ? 0 : pick_gap();
        end
      end
    end
    req_valid <= next_valid;
    // occasionally flip into or out of a stretch with no gaps
    if ($urandom_range(0, 199) == 0) send_calm = !send_calm;
  end

  // ---------------------------------------------------------------------------
  // output stall: falling edge, random stall runs
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      pred_stall <= 1'b1;
    end else begin
      pred_stall <= 1'b0;
      if (!recv_calm) stall_left = pick_gap();
    end
    if ($urandom_range(0, 199) == 0) recv_calm = !recv_calm;
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    qpel_pos_t pos;
    int        flavor_roll;
    rst         = 1'b1;
    req_valid   = 1'b0;
    pred_stall  = 1'b0;
    window_row0 = '0;
    window_row1 = '0;
    window_row2 = '0;
    window_row3 = '0;
    window_row4 = '0;
    window_row5 = '0;
    phase_x     = '0;
    phase_y     = '0;
    mismatches  = 0;
    cycle_count = 0;
    gap_left    = 0;
    stall_left  = 0;
    req_taken   = 1'b0;
    send_calm   = 1'b0;
    recv_calm   = 1'b0;

    // every quarter position once, over a random window
    pos = pos.first();
    do begin
      queue_req(rand_window(0), pos, 1'b0);
      pos = pos.next();
    end while (pos != pos.first());

    // flat extremes
    queue_req(sign_pattern(-1, 1'b0, 1'b0), POS_J, 1'b0);
    queue_req(sign_pattern(1, 1'b0, 1'b0), POS_E, 1'b0);
    // horizontal sum floored to zero, then saturated
    queue_req(sign_pattern(-1, 1'b1, 1'b0), POS_B, 1'b0);
    queue_req(sign_pattern(1, 1'b1, 1'b0), POS_C, 1'b0);
    // vertical sum floored to zero, then saturated
    queue_req(sign_pattern(-1, 1'b0, 1'b1), POS_H, 1'b0);
    queue_req(sign_pattern(1, 1'b0, 1'b1), POS_D, 1'b0);
    // centre sum at both ends, plus the column-3 and row-3 half samples
    queue_req(sign_pattern(-1, 1'b1, 1'b1), POS_J, 1'b0);
    queue_req(sign_pattern(1, 1'b1, 1'b1), POS_J, 1'b0);
    queue_req(sign_pattern(-1, 1'b1, 1'b1), POS_R, 1'b0);
    queue_req(sign_pattern(1, 1'b1, 1'b1), POS_K, 1'b0);

    // random part; the first one, if it draws a uniform window, waits for the directed samples to drain
    for (int i = 0; i < RandomReqs; i++) begin
      flavor_roll = $urandom_range(0, 99);
      pos = qpel_pos_t'($urandom_range(0, 15));
      if (flavor_roll < 50)
        queue_req(rand_window(0), pos, i == 0 || $urandom_range(0, 149) == 0);
      else if (flavor_roll < 75)
        queue_req(rand_window(1), pos, $urandom_range(0, 149) == 0);
      else if (flavor_roll < 90)
        queue_req(rand_window(2), pos, $urandom_range(0, 149) == 0);
      else
        queue_req(sign_pattern($urandom_range(0, 1) ? 1 : -1, 1'($urandom), 1'($urandom)),
                  pos, 1'b0);
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // wait for the last request to go in and its sample to come back;
    // checked at the rising edge, where the driver's pins have settled
    while (pending_reqs.size() != 0 || req_valid || expected_samples.size() != 0)
      @(posedge clk);
    // let the pipeline settle to catch stray samples
    repeat (SettleWait) @(negedge clk);

    // a prediction still waiting means a sample never came back
    if (expected_samples.size() != 0) begin
      mismatches++;
      if (mismatches <= ReportLimit)
        $display("%0d samples missing at end of run", expected_samples.size());
    end

    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
